FILE: hdl/deglitched_trimmed_mean_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Deglitched trimmed mean filter: assertion macros
// Shared concurrent assertion forms for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef DEGLITCHED_TRIMMED_MEAN_FILTER_UNIT_MACROS_SVH
`define DEGLITCHED_TRIMMED_MEAN_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define DTMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtmf check failed");

// next-cycle implication
`define DTMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtmf check failed");

`endif

FILE: hdl/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// Deglitched trimmed mean filter package
// Sample type, rank tracker control struct and sequencer state codes.
// ----------------------------------------------------------------------------
package dtmf_pkg;

   localparam int SAMPLE_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   // rank tracker control
   typedef struct packed {
      logic clear;
      logic take;
   } rank_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_START = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

endpackage

FILE: hdl/deglitched_trimmed_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// Deglitched trimmed mean filter unit
// Deglitches each sample against the newest window entry, pushes it into a
// DEPTH-slot cell chain and returns the window mean without its two smallest
// and two largest entries.
// ----------------------------------------------------------------------------
//  channel   ports                       beat
//  req       req_valid/req_ready         one raw sample
//  rsp       rsp_valid/rsp_ready         one trimmed mean
//
//  An item passes from one req beat to the next through the accept cycle,
//  the rotation of the cell chain once around past the rank tracker, the
//  divider start, the reciprocal divider and the load of the output
//  register, which raises rsp_valid. The load waits while an unaccepted
//  result holds the output register. Synchronous reset clears the window
//  to zero.
// ----------------------------------------------------------------------------
module deglitched_trimmed_mean_filter_unit #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dtmf_pkg::sample_type  req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dtmf_pkg::sample_type  rsp_filtered
);
   import dtmf_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_filtered_ff, rsp_filtered_in;

   sample_type       win_q [DEPTH];
   sample_type       head_d;
   logic             win_en;
   sample_type       prev;
   logic signed [SAMPLE_W:0] diff;
   sample_type       stored;
   rank_ctl_type     rank_ctl;
   logic signed [SUM_W-1:0] trim_sum;
   logic             div_start;
   logic             div_done;
   sample_type       div_quot;
   logic             accept;
   logic             out_free;

   assign prev = win_q[0];
   assign diff = {req_sample[SAMPLE_W-1], req_sample} - {prev[SAMPLE_W-1], prev};

   // (7*s + 3*prev)/10 collapses to a unit step toward zero when |diff| is 1
   always_comb begin
      stored = req_sample;
      if (diff == 17'sd1 && req_sample > 16'sd0) begin
         stored = req_sample - 16'sd1;
      end else if (diff == -17'sd1 && req_sample < 16'sd0) begin
         stored = req_sample + 16'sd1;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in = rsp_filtered_ff;
      win_en          = 1'b0;
      head_d          = win_q[DEPTH-1];
      rank_ctl        = '0;
      div_start       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               win_en         = 1'b1;
               head_d         = stored;
               rank_ctl.clear = 1'b1;
               cnt_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // rotate the chain once around, feeding the tail to the tracker
            win_en        = 1'b1;
            rank_ctl.take = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = div_quot;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff          <= cnt_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sample_type cell_d;
      if (i == 0) begin : g_head
         assign cell_d = head_d;
      end else begin : g_body
         assign cell_d = win_q[i-1];
      end
      dtmf_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (win_en),
         .d_in  (cell_d),
         .q     (win_q[i])
      );
   end

   dtmf_rank #(
      .SUM_W (SUM_W)
   ) u_rank (
      .clock    (clock),
      .ctl      (rank_ctl),
      .x        (win_q[DEPTH-1]),
      .trim_sum (trim_sum)
   );

   dtmf_div #(
      .SUM_W   (SUM_W),
      .DIVISOR (DEPTH - 4)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (trim_sum),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule

FILE: hdl/dtmf_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One slot of the sample window; loads its input value when enabled.
// ----------------------------------------------------------------------------
module dtmf_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  dtmf_pkg::sample_type d_in,
   output dtmf_pkg::sample_type q
);
   import dtmf_pkg::*;

   sample_type val_ff;
   sample_type val_in;

   assign val_in = en ? d_in : val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   assign q = val_ff;

endmodule

FILE: hdl/dtmf_rank.sv
// ----------------------------------------------------------------------------
// Rank tracker
// Sums the streamed window entries and keeps its two smallest and two
// largest values; reports the sum of the remaining entries.
// ----------------------------------------------------------------------------
module dtmf_rank #(
   parameter int SUM_W = 19
) (
   input  logic                  clock,
   input  dtmf_pkg::rank_ctl_type ctl,
   input  dtmf_pkg::sample_type   x,
   output logic signed [SUM_W-1:0] trim_sum
);
   import dtmf_pkg::*;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   sample_type lo0_ff, lo0_in, lo1_ff, lo1_in;
   sample_type hi0_ff, hi0_in, hi1_ff, hi1_in;

   function automatic logic signed [SUM_W-1:0] sext(input sample_type v);
      sext = {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
   endfunction

   always_comb begin
      sum_in = sum_ff;
      lo0_in = lo0_ff;
      lo1_in = lo1_ff;
      hi0_in = hi0_ff;
      hi1_in = hi1_ff;
      if (ctl.clear) begin
         sum_in = '0;
         lo0_in = SAMPLE_MAX;
         lo1_in = SAMPLE_MAX;
         hi0_in = SAMPLE_MIN;
         hi1_in = SAMPLE_MIN;
      end else if (ctl.take) begin
         sum_in = sum_ff + sext(x);
         if (x < lo0_ff) begin
            lo0_in = x;
            lo1_in = lo0_ff;
         end else if (x < lo1_ff) begin
            lo1_in = x;
         end
         if (x > hi0_ff) begin
            hi0_in = x;
            hi1_in = hi0_ff;
         end else if (x > hi1_ff) begin
            hi1_in = x;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      lo0_ff <= lo0_in;
      lo1_ff <= lo1_in;
      hi0_ff <= hi0_in;
      hi1_ff <= hi1_in;
   end

   // drop two extremes at each end
   assign trim_sum = sum_ff - sext(lo0_ff) - sext(lo1_ff) - sext(hi0_ff) - sext(hi1_ff);

endmodule

FILE: hdl/dtmf_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Signed division of a sum by a fixed divisor through reciprocal
// multiplication, truncating toward zero; start passes through the mul and done registers to raise done.
// ----------------------------------------------------------------------------
module dtmf_div #(
   parameter int SUM_W   = 19,
   parameter int DIVISOR = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [SUM_W-1:0] num,
   output logic                 done,
   output dtmf_pkg::sample_type  quot
);
   import dtmf_pkg::*;

   // |num| * ceil(2^SHIFT / DIVISOR) >> SHIFT is exact for |num| < 2^SUM_W
   localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic                mul_ff, mul_in;
   logic                done_ff, done_in;
   logic [SUM_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SAMPLE_W-1:0] q_mag;

   always_comb begin
      mul_in  = start;
      done_in = mul_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (start) begin
         neg_in = num[SUM_W-1];
         mag_in = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
      end
      if (mul_ff) begin
         prod_in = PROD_W'(mag_ff) * PROD_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign q_mag = prod_ff[SHIFT +: SAMPLE_W];
   assign quot  = neg_ff ? sample_type'(-q_mag) : sample_type'(q_mag);
   assign done  = done_ff;

endmodule

FILE: hdl/dtmf_checker.sv
// ----------------------------------------------------------------------------
// Deglitched trimmed mean filter checker
// Port-level checks of the filter's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "deglitched_trimmed_mean_filter_unit_macros.svh"

module dtmf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input dtmf_pkg::sample_type req_sample,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input dtmf_pkg::sample_type rsp_filtered
);
   import dtmf_pkg::*;

   // come out of reset idle and empty
   `DTMF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready)

   // a taken sample blocks the input until its result is out
   `DTMF_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready)

   // a new result arrives together with the input reopening
   `DTMF_ASSERT_IMPL(a_result_frees_input, clock, reset, $rose(rsp_valid), req_ready)

   // hold a stalled result beat
   `DTMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_filtered))

   // hold a waiting sample beat
   `DTMF_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
                     req_valid && $stable(req_sample))

endmodule

bind deglitched_trimmed_mean_filter_unit dtmf_checker u_dtmf_checker (.*);
